// File: hdl/microcluster_feature_update_defines.svh
// ---------------------------------------------------------------------------
// Micro-cluster feature update: assertion macros
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef MICROCLUSTER_FEATURE_UPDATE_DEFINES_SVH
`define MICROCLUSTER_FEATURE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define MCFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCFU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCFU_ASSERT(lbl, prop, msg)
`define MCFU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hdl/mcfu_pkg.sv
// ---------------------------------------------------------------------------
// Micro-cluster feature update: shared package
// Opcodes, field widths and the response type of the iterative units.
// ---------------------------------------------------------------------------
package mcfu_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ABSORB = 2'd1,
        OP_DIST   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_DIST   = 1'b1;

    localparam int X_W    = 16;
    localparam int LS_W   = 40;
    localparam int SS_W   = 56;
    localparam int C_W    = 16;
    localparam int ACC_W  = 64;
    localparam int OUT_W  = 24;
    localparam int DIMS_W = 5;
    localparam int UW     = 64;   // iterative unit operand width
    localparam int STEP_W = 6;    // divider step counter

    localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd2;

    typedef struct packed {
        logic          done;
        logic [UW-1:0] value;
    } unit_rsp_t;

    function automatic logic [OUT_W-1:0] sat24(input logic [UW-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > UW'({OUT_W{1'b1}}))
            r = '1;
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

// File: hdl/mcfu_div.sv
// ---------------------------------------------------------------------------
// Micro-cluster feature update: iterative divider
// Unsigned restoring divide, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mcfu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mcfu_pkg::UW-1:0]     dividend,
    input  logic [mcfu_pkg::UW-1:0]     divisor,
    output mcfu_pkg::unit_rsp_t         rsp
);

    logic [mcfu_pkg::UW-1:0]     quot_reg;
    logic [mcfu_pkg::UW-1:0]     rem_reg;
    logic [mcfu_pkg::UW-1:0]     dvs_reg;
    logic [mcfu_pkg::STEP_W-1:0] step_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [mcfu_pkg::UW:0]       trial;
    logic                        fits;

    assign trial = {rem_reg, quot_reg[mcfu_pkg::UW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == '1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            if (fits)
                rem_reg <= mcfu_pkg::UW'(trial - {1'b0, dvs_reg});
            else
                rem_reg <= trial[mcfu_pkg::UW-1:0];
            quot_reg <= {quot_reg[mcfu_pkg::UW-2:0], fits};
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quot_reg;

endmodule

// File: hdl/mcfu_isqrt.sv
// ---------------------------------------------------------------------------
// Micro-cluster feature update: iterative integer square root
// Floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module mcfu_isqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [mcfu_pkg::UW-1:0] operand,
    output mcfu_pkg::unit_rsp_t     rsp
);

    localparam int SQ_STEPS = mcfu_pkg::UW / 2;
    localparam int SQ_CW    = $clog2(SQ_STEPS);

    logic [mcfu_pkg::UW-1:0] v_reg;
    logic [mcfu_pkg::UW-1:0] r_reg;
    logic [mcfu_pkg::UW-1:0] bit_reg;
    logic [SQ_CW-1:0]        step_reg;
    logic                    run_reg;
    logic                    done_reg;
    logic [mcfu_pkg::UW-1:0] rb;

    assign rb = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == '1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= operand;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(mcfu_pkg::UW-2){1'b0}}};
        end
        else if (run_reg)
        begin
            if (v_reg >= rb)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

endmodule

// File: hdl/microcluster_feature_update.sv
// ---------------------------------------------------------------------------
// Micro-cluster feature update
// Keeps one stream micro-cluster and reports its radius or a point distance.
// ---------------------------------------------------------------------------
// One beat per start while busy is low. A clear beat finishes in the cycle
// it is taken. A beat that is not the last dimension passes the multiply and
// accumulate states; absorb also waits on the 64-step shared divider
// that forms the centroid. On the last dimension an absorb beat adds a
// multiply step, then, with a nonzero count and a positive sum, a second
// 64-step divide and a 32-step square root; a distance beat with a positive
// sum adds the square root only. The result shows for exactly one cycle
// with done high; the receiver cannot stall it, and the next beat may be
// taken in that same cycle. Write dims_in_use only while busy is low.
// ---------------------------------------------------------------------------
`include "microcluster_feature_update_defines.svh"

module microcluster_feature_update #(
    parameter int DIM_MAX    = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [3:0]                         coord_index,
    input  logic signed [mcfu_pkg::X_W-1:0]    coord_value,
    input  logic                               dims_wr_en,
    input  logic [mcfu_pkg::DIMS_W-1:0]        dims_wr_data,
    output logic                               done,
    output logic                               result_kind,
    output logic [mcfu_pkg::OUT_W-1:0]         radius,
    output logic [mcfu_pkg::OUT_W-1:0]         distance,
    output logic [mcfu_pkg::OUT_W-1:0]         point_count
);

    localparam int AW     = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int IW     = 8;
    localparam int WORD_W = mcfu_pkg::LS_W + mcfu_pkg::SS_W + mcfu_pkg::C_W;
    localparam int LS_LO  = mcfu_pkg::SS_W + mcfu_pkg::C_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_CWAIT = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_RGO   = 8'b0010_0000,
        S_RWAIT = 8'b0100_0000,
        S_SWAIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // cluster store: {linear sum, square sum, centroid} per dimension
    logic [WORD_W-1:0]  mem [DIM_MAX];
    logic [DIM_MAX-1:0] valid_reg;

    logic [WORD_W-1:0]               rd_word_reg;
    logic                            rd_ok_reg;
    logic [mcfu_pkg::DIMS_W-1:0]     dims_reg;
    logic [COUNT_BITS-1:0]           count_reg, count_next;
    logic signed [mcfu_pkg::ACC_W-1:0] acc_reg, acc_next;

    mcfu_pkg::opcode_t               op_reg;
    logic [AW-1:0]                   addr_reg;
    logic signed [mcfu_pkg::X_W-1:0] x_reg;
    logic                            last_reg;

    logic signed [31:0]              xx_reg;
    logic signed [mcfu_pkg::SS_W-1:0] lsx_reg;
    logic signed [33:0]              dd_reg;
    logic signed [mcfu_pkg::LS_W:0]  s_reg;
    logic [mcfu_pkg::UW-1:0]         nn_reg;

    logic                            done_reg;
    logic                            kind_reg;
    logic [mcfu_pkg::OUT_W-1:0]      radius_reg;
    logic [mcfu_pkg::OUT_W-1:0]      distance_reg;
    logic [mcfu_pkg::OUT_W-1:0]      pcount_reg;

    // accept decode
    logic            accept;
    logic            op_ok;
    logic [IW-1:0]   idx_ext;
    logic [IW-1:0]   last_idx;

    assign accept  = start && !busy;
    assign idx_ext = IW'(coord_index);
    assign op_ok   = (opcode == mcfu_pkg::OP_ABSORB || opcode == mcfu_pkg::OP_DIST)
                     && (idx_ext < IW'(DIM_MAX));

    always_comb
    begin
        if (dims_reg == '0)
            last_idx = '0;
        else if (IW'(dims_reg) > IW'(DIM_MAX))
            last_idx = IW'(DIM_MAX - 1);
        else
            last_idx = IW'(dims_reg) - IW'(1);
    end

    // fetched entry, zero when never written since clear
    logic signed [mcfu_pkg::LS_W-1:0] ent_ls;
    logic [mcfu_pkg::SS_W-1:0]        ent_ss;
    logic signed [mcfu_pkg::C_W-1:0]  ent_c;
    logic signed [16:0]               diff;

    assign ent_ls = rd_ok_reg ? rd_word_reg[WORD_W-1:LS_LO] : '0;
    assign ent_ss = rd_ok_reg ? rd_word_reg[LS_LO-1:mcfu_pkg::C_W] : '0;
    assign ent_c  = rd_ok_reg ? rd_word_reg[mcfu_pkg::C_W-1:0] : '0;
    assign diff   = ent_c - x_reg;

    // accumulate: absorb term or squared difference, saturating
    logic signed [65:0] term;
    logic signed [65:0] addend;
    logic signed [65:0] sum66;

    assign term   = $signed({10'b0, ent_ss}) + xx_reg - (lsx_reg <<< 1);
    assign addend = (op_reg == mcfu_pkg::OP_ABSORB) ? term : 66'(dd_reg);
    assign sum66  = 66'(acc_reg) + addend;

    always_comb
    begin
        acc_next = acc_reg;
        if (sum66[65:63] == 3'b000 || sum66[65:63] == 3'b111)
            acc_next = sum66[63:0];
        else if (sum66[65])
            acc_next = {1'b1, {(mcfu_pkg::ACC_W-1){1'b0}}};
        else
            acc_next = {1'b0, {(mcfu_pkg::ACC_W-1){1'b1}}};
    end

    // centroid division operands and write-back values
    logic [mcfu_pkg::LS_W:0]          s_mag;
    logic [COUNT_BITS:0]              cnt_inc;
    logic [2*COUNT_BITS:0]            nn_full;
    logic                             acc_pos;

    assign s_mag   = s_reg[mcfu_pkg::LS_W] ? (~s_reg + 1'b1) : s_reg;
    assign cnt_inc = {1'b0, count_reg} + 1'b1;
    assign nn_full = count_reg * cnt_inc;
    assign acc_pos = !acc_reg[mcfu_pkg::ACC_W-1] && (acc_reg != '0);

    logic signed [mcfu_pkg::LS_W-1:0] ls_new;
    logic [mcfu_pkg::SS_W:0]          ss_sum;
    logic [mcfu_pkg::SS_W-1:0]        ss_new;
    logic [mcfu_pkg::C_W-1:0]         c_new;
    logic [mcfu_pkg::UW-1:0]          q;

    assign ss_sum = {1'b0, ent_ss} + (mcfu_pkg::SS_W + 1)'(unsigned'(xx_reg));
    assign ss_new = ss_sum[mcfu_pkg::SS_W] ? '1 : ss_sum[mcfu_pkg::SS_W-1:0];

    always_comb
    begin
        if (s_reg[mcfu_pkg::LS_W] == s_reg[mcfu_pkg::LS_W-1])
            ls_new = s_reg[mcfu_pkg::LS_W-1:0];
        else if (s_reg[mcfu_pkg::LS_W])
            ls_new = {1'b1, {(mcfu_pkg::LS_W-1){1'b0}}};
        else
            ls_new = {1'b0, {(mcfu_pkg::LS_W-1){1'b1}}};

        // truncate toward zero, clamp into signed 16 bits
        if (!s_reg[mcfu_pkg::LS_W])
            c_new = (q > 64'd32767) ? 16'h7FFF : q[15:0];
        else
            c_new = (q > 64'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
    end

    always_comb
    begin
        if (count_reg == '1)
            count_next = count_reg;
        else
            count_next = count_reg + 1'b1;
    end

    // shared iterative units
    logic                    div_start;
    logic [mcfu_pkg::UW-1:0] div_a;
    logic [mcfu_pkg::UW-1:0] div_b;
    logic                    sq_start;
    logic [mcfu_pkg::UW-1:0] sq_in;
    mcfu_pkg::unit_rsp_t     div_rsp;
    mcfu_pkg::unit_rsp_t     sq_rsp;

    assign q = div_rsp.value;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = mcfu_pkg::UW'(s_mag);
        div_b     = mcfu_pkg::UW'(cnt_inc);
        sq_start  = 1'b0;
        sq_in     = div_rsp.value;
        if (state_reg == S_ACC && op_reg == mcfu_pkg::OP_ABSORB)
            div_start = 1'b1;
        if (state_reg == S_RGO)
        begin
            div_start = 1'b1;
            div_a     = unsigned'(acc_reg);
            div_b     = nn_reg;
        end
        if (state_reg == S_RWAIT && div_rsp.done)
            sq_start = 1'b1;
        if (state_reg == S_PREP && op_reg == mcfu_pkg::OP_DIST && acc_pos)
        begin
            sq_start = 1'b1;
            sq_in    = unsigned'(acc_reg);
        end
    end

    mcfu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .rsp      (div_rsp)
    );

    mcfu_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_in),
        .rsp     (sq_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op_ok)
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                if (op_reg == mcfu_pkg::OP_ABSORB)
                    state_next = S_CWAIT;
                else if (last_reg)
                    state_next = S_PREP;
                else
                    state_next = S_IDLE;
            end
            S_CWAIT:
            begin
                if (div_rsp.done)
                    state_next = last_reg ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                if (op_reg == mcfu_pkg::OP_ABSORB)
                    state_next = (count_reg != '0 && acc_pos) ? S_RGO : S_IDLE;
                else
                    state_next = acc_pos ? S_SWAIT : S_IDLE;
            end
            S_RGO:
                state_next = S_RWAIT;
            S_RWAIT:
            begin
                if (div_rsp.done)
                    state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (sq_rsp.done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // a result leaves when the last dimension finishes
    logic                       fin;
    logic [mcfu_pkg::OUT_W-1:0] fin_val;

    always_comb
    begin
        fin     = 1'b0;
        fin_val = '0;
        if (state_reg == S_PREP && state_next == S_IDLE)
            fin = 1'b1;
        if (state_reg == S_SWAIT && sq_rsp.done)
        begin
            fin     = 1'b1;
            fin_val = mcfu_pkg::sat24(sq_rsp.value);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            acc_reg   <= '0;
            dims_reg  <= mcfu_pkg::DIMS_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (dims_wr_en)
                dims_reg <= dims_wr_data;
            if (accept && opcode == mcfu_pkg::OP_CLEAR)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                acc_reg   <= '0;
            end
            if (state_reg == S_ACC)
                acc_reg <= acc_next;
            if (state_reg == S_CWAIT && div_rsp.done)
                valid_reg[addr_reg] <= 1'b1;
            if (fin)
            begin
                acc_reg <= '0;
                if (op_reg == mcfu_pkg::OP_ABSORB)
                    count_reg <= count_next;
            end
        end
    end

    // memory port and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_word_reg <= mem[AW'(coord_index)];
            rd_ok_reg   <= valid_reg[AW'(coord_index)];
            op_reg      <= mcfu_pkg::opcode_t'(opcode);
            addr_reg    <= AW'(coord_index);
            x_reg       <= coord_value;
            last_reg    <= (idx_ext == last_idx);
        end
        if (state_reg == S_CWAIT && div_rsp.done)
            mem[addr_reg] <= {ls_new, ss_new, c_new};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            xx_reg  <= x_reg * x_reg;
            lsx_reg <= ent_ls * x_reg;
            dd_reg  <= diff * diff;
            s_reg   <= ent_ls + x_reg;
        end
        if (state_reg == S_PREP)
            nn_reg <= mcfu_pkg::UW'(nn_full);
        if (fin)
        begin
            if (op_reg == mcfu_pkg::OP_ABSORB)
            begin
                kind_reg     <= mcfu_pkg::KIND_ABSORB;
                radius_reg   <= fin_val;
                distance_reg <= '0;
                pcount_reg   <= mcfu_pkg::sat24(mcfu_pkg::UW'(count_next));
            end
            else
            begin
                kind_reg     <= mcfu_pkg::KIND_DIST;
                radius_reg   <= '0;
                distance_reg <= fin_val;
                pcount_reg   <= mcfu_pkg::sat24(mcfu_pkg::UW'(count_reg));
            end
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign radius      = radius_reg;
    assign distance    = distance_reg;
    assign point_count = pcount_reg;

    // checks
    `MCFU_ASSERT(a_kind_zero, done |-> (result_kind ? (radius == '0) : (distance == '0)), "result of one kind carries the other field")
    `MCFU_ASSERT(a_work_busy, (start && !busy && (opcode == mcfu_pkg::OP_ABSORB || opcode == mcfu_pkg::OP_DIST) && (coord_index < DIM_MAX)) |=> busy, "accepted coordinate did not start work")
    `MCFU_ASSERT(a_div_wait, div_rsp.done |-> (state_reg == S_CWAIT || state_reg == S_RWAIT), "divider finished while nobody waited")
    `MCFU_ASSERT(a_sq_wait, sq_rsp.done |-> (state_reg == S_SWAIT), "square root finished while nobody waited")
    `MCFU_ASSERT_RST(a_rst_quiet, !rst_n |-> (!done && !busy), "result or work during reset")

endmodule

// File: sim/tb_microcluster_feature_update.sv
// ---------------------------------------------------------------------------
// Micro-cluster feature update testbench
// Drives clear, absorb and distance beats with changing dims_in_use and
// random start gaps. A scoreboard class predicts radius, distance and count
// and checks each done strobe against the oldest expected result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_microcluster_feature_update;

    localparam int NDIM      = 16;
    localparam int WDOG_MAX  = 20000;
    localparam logic [23:0] OUT_MAX   = 24'hFFFFFF;
    localparam longint      LS_MAX    = 64'sd549755813887;
    localparam longint      LS_MIN    = -64'sd549755813888;
    localparam longint unsigned SS_MAX = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct {
        logic        kind;
        logic [23:0] rad;
        logic [23:0] dst;
        logic [23:0] cnt;
    } cluster_result_t;

    int error_count = 0;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Floor integer square root.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0) s = 64'h7FFF_FFFF_FFFF_FFFF;
        if (a < 0 && b < 0 && s >= 0) s = 64'h8000_0000_0000_0000;
        return s;
    endfunction

    function automatic logic [23:0] clip24(input longint unsigned v);
        return (v > 64'(OUT_MAX)) ? OUT_MAX : v[23:0];
    endfunction

    class cluster_scoreboard;
        longint          lin_sum [NDIM];
        longint unsigned sq_sum  [NDIM];
        longint          centroid[NDIM];
        longint unsigned points;
        longint          acc;
        logic [4:0]      dims;
        cluster_result_t pending[$];

        function void wipe();
            for (int i = 0; i < NDIM; i++) begin
                lin_sum[i] = 0;
                sq_sum[i] = 0;
                centroid[i] = 0;
            end
            points = 0;
            acc = 0;
        endfunction

        // Predict the effect of one accepted beat.
        function void note_beat(input mcfu_pkg::opcode_t op, input logic [3:0] idx,
                                input logic signed [15:0] x);
            longint xs, xx, term, s, c, d;
            longint unsigned eff, q, r, ssn;
            cluster_result_t res;
            if (op == mcfu_pkg::OP_CLEAR) begin
                wipe();
                return;
            end
            if (op == mcfu_pkg::OP_NONE) return;
            eff = (dims == 0) ? 1 : ((dims > NDIM) ? NDIM : dims);
            xs = x;
            if (op == mcfu_pkg::OP_ABSORB) begin
                xx = xs * xs;
                term = longint'(sq_sum[idx]) + xx - 2 * lin_sum[idx] * xs;
                s = lin_sum[idx] + xs;
                c = s / longint'(points + 1);
                acc = sat_add(acc, term);
                if (c > 32767) c = 32767;
                if (c < -32768) c = -32768;
                centroid[idx] = c;
                if (s > LS_MAX) s = LS_MAX;
                if (s < LS_MIN) s = LS_MIN;
                lin_sum[idx] = s;
                ssn = sq_sum[idx] + longint'(xx);
                sq_sum[idx] = (ssn > SS_MAX) ? SS_MAX : ssn;
            end
            else begin
                d = centroid[idx] - xs;
                acc = sat_add(acc, d * d);
            end
            if (idx != eff - 1) return;
            if (op == mcfu_pkg::OP_ABSORB) begin
                r = 0;
                if (points != 0 && acc > 0) begin
                    q = longint'(acc) / (points * (points + 1));
                    r = floor_sqrt(q);
                end
                if (points < 64'(OUT_MAX)) points++;
                res.kind = mcfu_pkg::KIND_ABSORB;
                res.rad  = clip24(r);
                res.dst  = '0;
            end
            else begin
                r = (acc > 0) ? floor_sqrt(acc) : 0;
                res.kind = mcfu_pkg::KIND_DIST;
                res.rad  = '0;
                res.dst  = clip24(r);
            end
            res.cnt = clip24(points);
            acc = 0;
            pending = {pending, res};
        endfunction

        task check_result(input logic k, input logic [23:0] rad,
                          input logic [23:0] dval, input logic [23:0] cnt);
            cluster_result_t e;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
                report_mismatch($sformatf("kind %0b want %0b", k, e.kind));
            if (rad !== e.rad)
                report_mismatch($sformatf("radius %0d want %0d", rad, e.rad));
            if (dval !== e.dst)
                report_mismatch($sformatf("distance %0d want %0d", dval, e.dst));
            if (cnt !== e.cnt)
                report_mismatch($sformatf("count %0d want %0d", cnt, e.cnt));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 1;
    logic        start = 0;
    logic [1:0]  opcode = '0;
    logic [3:0]  coord_index = '0;
    logic signed [15:0] coord_value = '0;
    logic        dims_wr_en = 0;
    logic [4:0]  dims_wr_data = '0;
    logic        busy, done, result_kind;
    logic [23:0] radius, distance, point_count;

    cluster_scoreboard sb = new();
    int  idle_pct = 14;
    int  wdog = 0;

    always #4 clk = ~clk;

    microcluster_feature_update u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .coord_index  (coord_index),
        .coord_value  (coord_value),
        .dims_wr_en   (dims_wr_en),
        .dims_wr_data (dims_wr_data),
        .done         (done),
        .result_kind  (result_kind),
        .radius       (radius),
        .distance     (distance),
        .point_count  (point_count)
    );

    // Sample at the rising edge: note accepted beats, check results, and
    // advance the watchdog when nothing moves.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done)
                sb.check_result(result_kind, radius, distance, point_count);
            if (start && !busy)
                sb.note_beat(mcfu_pkg::opcode_t'(opcode), coord_index, coord_value);
            if (done || (start && !busy))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("tb_microcluster_feature_update: FAIL");
                $finish;
            end
        end
    end

    // Drive one beat and hold start until it is taken. Start stays high
    // into the next beat unless a gap is drawn, so back-to-back is covered.
    task automatic send_beat(input mcfu_pkg::opcode_t op, input logic [3:0] idx,
                             input logic signed [15:0] x);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge clk);
        end
        start       <= 1;
        opcode      <= op;
        coord_index <= idx;
        coord_value <= x;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Drop start and wait until every expected result has come, then let
    // the slowest beat's latency run out so the block is surely idle.
    task automatic drain();
        @(negedge clk);
        start <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_dims(input logic [4:0] v);
        drain();
        dims_wr_en   <= 1;
        dims_wr_data <= v;
        @(negedge clk);
        dims_wr_en <= 0;
        sb.dims = v;
    endtask

    // One point: in-order coordinates ending on the last dimension, now and then with a random opcode.
    task automatic send_point(input mcfu_pkg::opcode_t op, input int nd, input int mag);
        for (int i = 0; i < nd; i++)
            send_beat(($urandom_range(19) == 0) ?
                      mcfu_pkg::opcode_t'($urandom_range(2, 1)) : op,
                      4'(i), 16'($urandom_range(2 * mag) - mag));
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(4096) - 2048);
        endcase
    endfunction

    initial begin
        int n;
        int nd;
        rst_n <= 0;
        sb.wipe();
        sb.dims = mcfu_pkg::DIMS_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: default two dimensions, extremes, every opcode.
        idle_pct = 0;
        send_beat(mcfu_pkg::OP_ABSORB, 0, 16'sh7FFF);
        send_beat(mcfu_pkg::OP_ABSORB, 1, 16'sh8000);
        send_beat(mcfu_pkg::OP_ABSORB, 0, 16'sh8000);
        send_beat(mcfu_pkg::OP_ABSORB, 1, 16'sh7FFF);
        send_beat(mcfu_pkg::OP_DIST, 0, 16'sh0000);
        send_beat(mcfu_pkg::OP_DIST, 1, 16'shFFFF);
        send_beat(mcfu_pkg::OP_NONE, 1, 16'sh1234);
        send_beat(mcfu_pkg::OP_DIST, 0, 16'sh0100);   // mixed kinds in one point
        send_beat(mcfu_pkg::OP_ABSORB, 1, 16'sh0100);
        send_beat(mcfu_pkg::OP_ABSORB, 5, 16'sh0200); // above last: plain coordinate
        send_beat(mcfu_pkg::OP_ABSORB, 1, 16'sh5555);
        send_beat(mcfu_pkg::OP_CLEAR, 0, 16'sh0000);
        send_beat(mcfu_pkg::OP_ABSORB, 1, 16'shAAAA); // zero count: radius 0
        send_beat(mcfu_pkg::OP_DIST, 1, 16'sh0040);
        write_dims(5'd0);                             // acts as one dimension
        send_beat(mcfu_pkg::OP_ABSORB, 0, 16'sh0300);
        send_beat(mcfu_pkg::OP_ABSORB, 0, 16'sh0300); // identical points: radius 0
        send_beat(mcfu_pkg::OP_DIST, 0, 16'sh7FFF);
        write_dims(5'd16);
        send_beat(mcfu_pkg::OP_ABSORB, 15, 16'sh8000);
        send_beat(mcfu_pkg::OP_DIST, 15, 16'sh7FFF);
        write_dims(5'd20);                            // clamps to sixteen
        send_beat(mcfu_pkg::OP_DIST, 15, 16'sh0001);
        write_dims(5'd31);
        send_beat(mcfu_pkg::OP_ABSORB, 15, 16'sh0002);

        // Random: phases with different idle rates and dims settings.
        n = 0;
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 14 : ((ph < 4) ? 58 : 0);
            case (ph)
                0: write_dims(5'd1);
                1: write_dims(5'd3);
                2: write_dims(5'd16);
                3: write_dims(5'd2);
                4: write_dims(5'($urandom_range(31)));
                default: write_dims(5'd4);
            endcase
            send_beat(mcfu_pkg::OP_CLEAR, 4'($urandom), 16'($urandom));
            nd = (sb.dims == 0) ? 1 : ((sb.dims > NDIM) ? NDIM : sb.dims);
            while (n < 92 * (ph + 1)) begin
                case ($urandom_range(9))
                    0: begin
                        send_beat(mcfu_pkg::opcode_t'($urandom_range(3)), 4'($urandom),
                                  rand_coord());
                        n++;
                    end
                    1: begin
                        for (int i = 0; i < nd; i++)
                            send_beat(mcfu_pkg::OP_ABSORB, 4'(i), rand_coord());
                        n += nd;
                    end
                    2, 3, 4: begin
                        send_point(mcfu_pkg::OP_DIST, nd, 2048);
                        n += nd;
                    end
                    default: begin
                        send_point(mcfu_pkg::OP_ABSORB, nd, 1024);
                        n += nd;
                    end
                endcase
                if ($urandom_range(40) == 0) begin
                    send_beat(mcfu_pkg::OP_CLEAR, 0, 16'sh0000);
                    n++;
                end
                if (n % 50 == 0) drain();
            end
        end

        drain();
        if (error_count == 0 && sb.pending.size() == 0)
            $display("tb_microcluster_feature_update: PASS");
        else
            $display("tb_microcluster_feature_update: FAIL");
        $finish;
    end
endmodule
